// ----- hdl/sample_voice_mixer_defines.svh -----
// Assertion macros shared by the checker of the voice mixer.
`ifndef SAMPLE_VOICE_MIXER_DEFINES_SVH
`define SAMPLE_VOICE_MIXER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sample voice mixer: check failed");

// The consequent must hold in the cycle after the antecedent.
`define SVM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sample voice mixer: check failed");

`endif

// ----- hdl/svm_pkg.sv -----
package svm_pkg;

  localparam int VOICE_COUNT  = 8;
  localparam int SAMPLE_DEPTH = 65536;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int VIDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int REQ_W        = 2;
  localparam int ADDR_IN_W    = 16;
  localparam int LEN_W        = 17;
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = 19;

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  pos;
    logic              stereo;
  } voice_t;

endpackage

// ----- hdl/sample_voice_mixer.sv -----
// Eight-voice sample playback mixer over a shared 64K x 16 sample memory.
// Input channel (in_valid_i / in_stall_o) carries one request per transfer:
// write a sample, start a voice on a buffer, stop all voices, or tick one
// output frame. Every request yields exactly one result transfer on the
// output channel (out_valid_o / out_stall_i) with the frame sums (zero for
// non-tick requests), the claimed slot, the no-free-slot flag and the mask
// of playing voices after the request.
// One request is processed at a time. Write, start and stop pass through
// the execute and output states only. A tick walks the voice slots in
// order: an idle slot is skipped, an ending voice is retired, a mono voice
// reads one sample and a stereo voice a pair; the walk is paced by the single
// read port of the sample memory and the registered read of the voice table.
// The result sits in an output register, so a new request is accepted as
// soon as the previous one has been loaded there; while the receiver stalls
// with a result still held, the next result waits in its final step.
// Reset marks all voices idle; the voice table and sample memory are not
// cleared, and a sample address never written reads as anything.
module sample_voice_mixer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [svm_pkg::REQ_W-1:0]           req_type_i,
  input  logic [svm_pkg::ADDR_IN_W-1:0]       address_i,
  input  logic [svm_pkg::LEN_W-1:0]           buffer_length_i,
  input  logic                                stereo_mode_i,
  input  logic signed [svm_pkg::SAMPLE_W-1:0] sample_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [svm_pkg::SUM_W-1:0]    left_sum_o,
  output logic signed [svm_pkg::SUM_W-1:0]    right_sum_o,
  output logic [svm_pkg::VIDX_W-1:0]          slot_index_o,
  output logic                                no_free_slot_o,
  output logic [svm_pkg::VOICE_COUNT-1:0]     active_mask_o
);
  import svm_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_VREAD = 3'd2;
  localparam logic [2:0] ST_VEVAL = 3'd3;
  localparam logic [2:0] ST_SAMP0 = 3'd4;
  localparam logic [2:0] ST_SAMP1 = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [VIDX_W-1:0] v_q, v_d;
  logic [VOICE_COUNT-1:0] active_q, active_d;
  logic signed [SUM_W-1:0] left_q, left_d, right_q, right_d;
  logic pair_q, pair_d;
  logic [VIDX_W-1:0] slot_q, slot_d;
  logic none_q, none_d;

  logic [REQ_W-1:0] req_q;
  logic [ADDR_IN_W-1:0] addr_q;
  logic [LEN_W-1:0] len_q;
  logic stereo_q;
  logic [SAMPLE_W-1:0] data_q;

  logic out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] out_left_q, out_right_q;
  logic [VIDX_W-1:0] out_slot_q;
  logic out_none_q;
  logic [VOICE_COUNT-1:0] out_mask_q;

  logic [SAMPLE_W-1:0] smem [SAMPLE_DEPTH];
  logic [SAMPLE_W-1:0] s_rdata_q;
  logic s_we, s_re;
  logic [ADDR_W-1:0] s_raddr;

  voice_t vmem [VOICE_COUNT];
  voice_t v_rdata_q, v_wdata;
  logic v_we, v_re;
  logic [VIDX_W-1:0] v_waddr;

  logic in_xfer, out_load, last_voice, voice_ends, voice_pair;
  logic [LEN_W:0] pos_p1;
  logic [ADDR_W-1:0] saddr0, saddr1;
  logic signed [SUM_W-1:0] samp_ext;
  logic free_found;
  logic [VIDX_W-1:0] free_idx;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign last_voice = (v_q == VIDX_W'(VOICE_COUNT - 1));

  assign pos_p1     = {1'b0, v_rdata_q.pos} + (LEN_W + 1)'(1);
  assign voice_ends = (v_rdata_q.pos >= v_rdata_q.length);
  assign voice_pair = v_rdata_q.stereo && (pos_p1 < {1'b0, v_rdata_q.length});
  assign saddr0     = v_rdata_q.base + v_rdata_q.pos[ADDR_W-1:0];
  assign saddr1     = saddr0 + ADDR_W'(1);
  assign samp_ext   = {{(SUM_W - SAMPLE_W){s_rdata_q[SAMPLE_W-1]}}, s_rdata_q};

  // Lowest idle slot wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
      if (!active_q[v]) begin
        free_found = 1'b1;
        free_idx   = VIDX_W'(v);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    v_d      = v_q;
    active_d = active_q;
    left_d   = left_q;
    right_d  = right_q;
    pair_d   = pair_q;
    slot_d   = slot_q;
    none_d   = none_q;
    s_we     = 1'b0;
    s_re     = 1'b0;
    s_raddr  = saddr0;
    v_we     = 1'b0;
    v_re     = 1'b0;
    v_waddr  = v_q;
    v_wdata  = v_rdata_q;
    out_load = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        left_d  = '0;
        right_d = '0;
        slot_d  = '0;
        none_d  = 1'b0;
        v_d     = '0;
        state_d = ST_OUT;
        unique case (req_q)
          REQ_TICK: begin
            state_d = ST_VREAD;
          end
          REQ_START: begin
            if (free_found) begin
              v_we    = 1'b1;
              v_waddr = free_idx;
              v_wdata = '{base: addr_q[ADDR_W-1:0], length: len_q, pos: '0,
                          stereo: stereo_q};
              active_d[free_idx] = 1'b1;
              slot_d  = free_idx;
            end else begin
              none_d = 1'b1;
            end
          end
          REQ_STOP: begin
            active_d = '0;
          end
          default: begin
            s_we = 1'b1;
          end
        endcase
      end
      ST_VREAD: begin
        if (active_q[v_q]) begin
          v_re    = 1'b1;
          state_d = ST_VEVAL;
        end else if (last_voice) begin
          state_d = ST_OUT;
        end else begin
          v_d = v_q + VIDX_W'(1);
        end
      end
      ST_VEVAL: begin
        if (voice_ends) begin
          active_d[v_q] = 1'b0;
          v_d     = v_q + VIDX_W'(1);
          state_d = last_voice ? ST_OUT : ST_VREAD;
        end else begin
          s_re    = 1'b1;
          s_raddr = saddr0;
          pair_d  = voice_pair;
          state_d = ST_SAMP0;
        end
      end
      ST_SAMP0: begin
        left_d = left_q + samp_ext;
        if (pair_q) begin
          s_re    = 1'b1;
          s_raddr = saddr1;
          state_d = ST_SAMP1;
        end else begin
          right_d     = right_q + samp_ext;
          v_we        = 1'b1;
          v_wdata.pos = pos_p1[LEN_W-1:0];
          v_d         = v_q + VIDX_W'(1);
          state_d     = last_voice ? ST_OUT : ST_VREAD;
        end
      end
      ST_SAMP1: begin
        right_d     = right_q + samp_ext;
        v_we        = 1'b1;
        v_wdata.pos = v_rdata_q.pos + LEN_W'(2);
        v_d         = v_q + VIDX_W'(1);
        state_d     = last_voice ? ST_OUT : ST_VREAD;
      end
      ST_OUT: begin
        // Wait here until the output register is free or being emptied.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    left_q  <= left_d;
    right_q <= right_d;
    pair_q  <= pair_d;
    slot_q  <= slot_d;
    none_q  <= none_d;
    if (in_xfer) begin
      req_q    <= req_type_i;
      addr_q   <= address_i;
      len_q    <= buffer_length_i;
      stereo_q <= stereo_mode_i;
      data_q   <= sample_data_i;
    end
    if (out_load) begin
      out_left_q  <= left_q;
      out_right_q <= right_q;
      out_slot_q  <= slot_q;
      out_none_q  <= none_q;
      out_mask_q  <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      smem[addr_q[ADDR_W-1:0]] <= data_q;
    end
    if (s_re) begin
      s_rdata_q <= smem[s_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    if (v_re) begin
      v_rdata_q <= vmem[v_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sum_o     = out_left_q;
  assign right_sum_o    = out_right_q;
  assign slot_index_o   = out_slot_q;
  assign no_free_slot_o = out_none_q;
  assign active_mask_o  = out_mask_q;

endmodule

// ----- hdl/svm_checker.sv -----
`include "sample_voice_mixer_defines.svh"

module svm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [svm_pkg::SUM_W-1:0]    left_sum_o,
  input logic signed [svm_pkg::SUM_W-1:0]    right_sum_o,
  input logic [svm_pkg::VIDX_W-1:0]          slot_index_o,
  input logic                                no_free_slot_o,
  input logic [svm_pkg::VOICE_COUNT-1:0]     active_mask_o
);
  import svm_pkg::*;

  // A held result keeps its valid, its sums and its mask.
  `SVM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `SVM_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(left_sum_o) && $stable(right_sum_o) && $stable(active_mask_o))

  // A start can only fail when every voice is playing.
  `SVM_ASSERT_NOW(a_full_mask, clk_i, rst_ni, out_valid_o && no_free_slot_o, (&active_mask_o) && (slot_index_o == '0))

  // One request at a time: after a transfer the input side is busy.
  `SVM_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind sample_voice_mixer svm_checker u_svm_checker (.*);

// ----- verif/tb_sample_voice_mixer.sv -----
`timescale 1ns / 100ps

module tb_sample_voice_mixer;
  import svm_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [REQ_W-1:0]           op;
    logic [ADDR_IN_W-1:0]       addr;
    logic [LEN_W-1:0]           len;
    logic                       stereo;
    logic signed [SAMPLE_W-1:0] data;
  } mix_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] left;
    logic signed [SUM_W-1:0] right;
    logic [VIDX_W-1:0]       slot;
    logic                    full;
    logic [VOICE_COUNT-1:0]  mask;
  } mix_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mix_req_t cur_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SUM_W-1:0] left_sum, right_sum;
  logic [VIDX_W-1:0] slot_index;
  logic no_free_slot;
  logic [VOICE_COUNT-1:0] active_mask;

  mix_req_t req_q[$];
  mix_res_t outcome_q[$];
  int unsigned issued = 0;
  int unsigned sent_total = 0;
  int unsigned calm_from = 32'hFFFF_FFFF;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;
  bit held_once = 1'b0;
  bit written [SAMPLE_DEPTH];
  mix_res_t want;
  logic calm;

  // Mirror of the mixer state, advanced once per accepted request.
  logic [SAMPLE_W-1:0] smem [SAMPLE_DEPTH];
  voice_t vc_tab [VOICE_COUNT];
  logic [VOICE_COUNT-1:0] vc_on = '0;

  assign calm = (sent_total >= calm_from);

  always #10 clk_i = ~clk_i;

  sample_voice_mixer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (cur_req.op),
    .address_i       (cur_req.addr),
    .buffer_length_i (cur_req.len),
    .stereo_mode_i   (cur_req.stereo),
    .sample_data_i   (cur_req.data),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .left_sum_o      (left_sum),
    .right_sum_o     (right_sum),
    .slot_index_o    (slot_index),
    .no_free_slot_o  (no_free_slot),
    .active_mask_o   (active_mask)
  );

  function automatic logic signed [SAMPLE_W-1:0] sample_at(logic [ADDR_W-1:0] base,
                                                           logic [LEN_W-1:0] off);
    logic [LEN_W:0] a;
    a = (LEN_W + 1)'(base) + (LEN_W + 1)'(off);
    return smem[a[ADDR_W-1:0]];
  endfunction

  function automatic mix_res_t apply_request(mix_req_t r);
    mix_res_t o;
    logic signed [SUM_W-1:0] acc_l, acc_r;
    logic signed [SAMPLE_W-1:0] s;
    logic [LEN_W-1:0] p;
    int v, slot_found;
    o = '0;
    acc_l = '0;
    acc_r = '0;
    slot_found = -1;
    case (r.op)
      REQ_TICK: begin
        for (v = 0; v < VOICE_COUNT; v++) begin
          if (vc_on[v]) begin
            p = vc_tab[v].pos;
            if (p >= vc_tab[v].length) begin
              vc_on[v] = 1'b0;
            end else if (vc_tab[v].stereo &&
                         (({1'b0, p} + (LEN_W + 1)'(1)) < {1'b0, vc_tab[v].length})) begin
              acc_l = acc_l + SUM_W'(sample_at(vc_tab[v].base, p));
              acc_r = acc_r + SUM_W'(sample_at(vc_tab[v].base, p + LEN_W'(1)));
              vc_tab[v].pos = p + LEN_W'(2);
            end else begin
              s = sample_at(vc_tab[v].base, p);
              acc_l = acc_l + SUM_W'(s);
              acc_r = acc_r + SUM_W'(s);
              vc_tab[v].pos = p + LEN_W'(1);
            end
          end
        end
      end
      REQ_START: begin
        for (v = VOICE_COUNT - 1; v >= 0; v--) begin
          if (!vc_on[v]) slot_found = v;
        end
        if (slot_found < 0) begin
          o.full = 1'b1;
        end else begin
          vc_tab[slot_found].base = r.addr;
          vc_tab[slot_found].length = r.len;
          vc_tab[slot_found].pos = '0;
          vc_tab[slot_found].stereo = r.stereo;
          vc_on[slot_found] = 1'b1;
          o.slot = VIDX_W'(slot_found);
        end
      end
      REQ_STOP: vc_on = '0;
      default: smem[r.addr] = r.data;
    endcase
    o.left = acc_l;
    o.right = acc_r;
    o.mask = vc_on;
    return o;
  endfunction

  task automatic cmp_field(input string name, input logic signed [31:0] exp_val,
                           input logic signed [31:0] got_val);
    if (got_val !== exp_val) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_write(input logic [ADDR_W-1:0] a, input logic signed [SAMPLE_W-1:0] d);
    mix_req_t r;
    r.op = REQ_WRITE;
    r.addr = a;
    r.len = LEN_W'($urandom_range(0, SAMPLE_DEPTH));
    r.stereo = 1'($urandom);
    r.data = d;
    req_q.push_back(r);
    written[a] = 1'b1;
    issued++;
  endtask

  task automatic send_start(input logic [ADDR_W-1:0] a, input logic [LEN_W-1:0] n,
                            input logic st);
    mix_req_t r;
    r.op = REQ_START;
    r.addr = a;
    r.len = n;
    r.stereo = st;
    r.data = SAMPLE_W'($urandom);
    req_q.push_back(r);
    issued++;
  endtask

  // Ticks and stops carry random content in the fields they do not use.
  task automatic send_ctl(input logic [REQ_W-1:0] op);
    mix_req_t r;
    r.op = op;
    r.addr = ADDR_IN_W'($urandom);
    r.len = LEN_W'($urandom_range(0, SAMPLE_DEPTH));
    r.stereo = 1'($urandom);
    r.data = SAMPLE_W'($urandom);
    req_q.push_back(r);
    issued++;
  endtask

  task automatic fill_buffer(input logic [ADDR_W-1:0] base, input int unsigned n);
    logic [ADDR_W-1:0] a;
    for (int unsigned i = 0; i < n; i++) begin
      a = base + ADDR_W'(i);
      if (!written[a]) send_write(a, pick_sample());
    end
  endtask

  // A voice can advance at most two samples per tick, so writing the first
  // 2 * (ticks still to come) samples of each buffer keeps every read on
  // written memory. Any voice that might outlive the batch is stopped.
  task automatic play_batch(input int unsigned ticks, input int unsigned voices);
    int unsigned t_left, v_left, span, pick;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0] len;
    bit lingering;
    t_left = ticks;
    v_left = voices;
    lingering = 1'b0;
    while (t_left + v_left > 0) begin
      pick = $urandom_range(0, 15);
      if (v_left > 0 && (pick < 5 || t_left == 0)) begin
        case ($urandom_range(0, 3))
          0: base = ADDR_W'($urandom);
          1: base = ADDR_W'(SAMPLE_DEPTH - 1 - $urandom_range(0, 8));
          default: base = ADDR_W'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 9) == 0) len = LEN_W'($urandom_range(0, SAMPLE_DEPTH));
        else len = LEN_W'($urandom_range(0, 2 * ticks + 2));
        span = (32'(len) < 2 * t_left) ? 32'(len) : 2 * t_left;
        fill_buffer(base, span);
        send_start(base, len, 1'($urandom));
        if (t_left < 32'(len) + 1) lingering = 1'b1;
        v_left--;
      end else if (pick == 15) begin
        if ($urandom_range(0, 3) == 0) begin
          send_ctl(REQ_STOP);
          lingering = 1'b0;
        end else begin
          send_write(ADDR_W'($urandom), pick_sample());
        end
      end else if (t_left > 0) begin
        send_ctl(REQ_TICK);
        t_left--;
      end
    end
    if (lingering || $urandom_range(0, 3) == 0) send_ctl(REQ_STOP);
  endtask

  task automatic run_batches(input int unsigned upto);
    int unsigned nv;
    while (issued < upto) begin
      nv = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 4);
      play_batch($urandom_range(1, 10), nv);
    end
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || outcome_q.size() != 0) @(negedge clk_i);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cur_req <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q.push_back(apply_request(cur_req));
        sent_total <= sent_total + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (req_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          gap_left <= $urandom_range(1, 18) - 1;
        end else begin
          in_valid <= 1'b1;
          cur_req <= req_q.pop_front();
        end
      end
    end
  end

  // Result monitor; it also drives the output stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $error("result with no request waiting: left_sum %0d right_sum %0d mask %b",
                 left_sum, right_sum, active_mask);
        end else begin
          want = outcome_q.pop_front();
          cmp_field("left_sum", 32'(want.left), 32'(left_sum));
          cmp_field("right_sum", 32'(want.right), 32'(right_sum));
          cmp_field("slot_index", 32'(want.slot), 32'(slot_index));
          cmp_field("no_free_slot", 32'(want.full), 32'(no_free_slot));
          cmp_field("active_mask", 32'(want.mask), 32'(active_mask));
          results_seen++;
        end
      end
      // One long hold lets the block fill up and push back on its input.
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!held_once && results_seen >= 120) begin
        held_once <= 1'b1;
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(1, 18) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("sample_voice_mixer test failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full-scale sums: eight stereo voices reading a pair that wraps from the
    // top of memory to address zero. The first voice is three samples long,
    // so its second tick is a stereo voice with a single sample left.
    send_write(16'hFFFF, 16'sh7FFF);
    send_write(16'h0000, 16'sh8000);
    send_write(16'h0001, 16'sh1234);
    send_start(16'hFFFF, 17'd3, 1'b1);
    repeat (VOICE_COUNT - 1) send_start(16'hFFFF, 17'd2, 1'b1);
    send_start(16'hFFFF, 17'h10000, 1'b1);
    send_ctl(REQ_TICK);
    send_ctl(REQ_TICK);
    send_start(16'h0000, 17'd0, 1'b0);
    send_ctl(REQ_TICK);
    send_start(16'h0000, 17'h10000, 1'b0);
    send_ctl(REQ_TICK);
    send_ctl(REQ_STOP);
    send_ctl(REQ_TICK);
    wait_drained();

    run_batches(issued + 230);
    wait_drained();
    run_batches(issued + 200);
    calm_from = issued;
    run_batches(issued + 70);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("sample_voice_mixer test passed");
    end else begin
      $display("sample_voice_mixer test failed");
    end
    $finish;
  end

endmodule
